// ===== design/smfs_pkg.sv =====
package smfs_pkg;

  localparam int SampleWidth = 14;
  localparam int SumWidth    = 20;
  localparam int ShiftWidth  = 16;
  localparam int SlotWidth   = 5;
  localparam int WinWidth    = 21;
  localparam int InWidth     = 16;
  localparam int OutWidth    = 8;

  localparam logic [SlotWidth-1:0] RightSlot = 5'd13;
  localparam logic [SlotWidth-1:0] LeftSlot  = 5'd29;

  localparam logic [3:0] PhaseSign    = 4'd0;
  localparam logic [3:0] PhaseExpLast = 4'd3;
  localparam logic [3:0] PhaseCapture = 4'd1;
  localparam logic [3:0] PhaseSearch  = 4'd7;

  typedef struct packed {
    logic left;
    logic right;
  } tap_t;

  // leading-bit search on the six bits below the sign
  function automatic logic [2:0] lead_exponent(input logic [6:0] cap);
    logic [5:0] top;
    logic [2:0] e;
    top = cap[6] ? cap[5:0] : ~cap[5:0];
    e = 3'd1;
    for (int i = 0; i < 6; i++) begin
      if (top[i]) begin
        e = 3'(i + 2);
      end
    end
    return e;
  endfunction

  // clamp codes: pass, force one, force zero
  function automatic logic stream_bit(input logic [2:0] clamp, input logic lsb);
    logic b;
    unique case (clamp)
      3'd0, 3'd7:       b = lsb;
      3'd1, 3'd2, 3'd3: b = 1'b1;
      default:          b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== design/smfs_mix.sv =====
module smfs_mix (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [smfs_pkg::SlotWidth-1:0]  slot,
  input  logic [smfs_pkg::SampleWidth-1:0] sample,
  input  logic                            add_left,
  input  logic                            add_right,
  output smfs_pkg::tap_t                  taps
);
  import smfs_pkg::*;

  logic [SumWidth-1:0]   sum_left;
  logic [SumWidth-1:0]   sum_right;
  logic [ShiftWidth-1:0] shifter_left;
  logic [ShiftWidth-1:0] shifter_right;
  logic [2:0]            clamp_left;
  logic [2:0]            clamp_right;
  logic [3:0]            delay_left;
  logic [3:0]            delay_right;
  logic [SumWidth-1:0]   sample_ext;
  logic                  new_left;
  logic                  new_right;

  assign sample_ext = SumWidth'(signed'(sample));
  assign new_left   = stream_bit(clamp_left, shifter_left[0]);
  assign new_right  = stream_bit(clamp_right, shifter_right[0]);
  assign taps.left  = delay_left[3];
  assign taps.right = delay_right[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_left      <= '0;
      sum_right     <= '0;
      shifter_left  <= '0;
      shifter_right <= '0;
      clamp_left    <= '0;
      clamp_right   <= '0;
      delay_left    <= '0;
      delay_right   <= '0;
    end else if (step) begin
      delay_left  <= {delay_left[2:0], new_left};
      delay_right <= {delay_right[2:0], new_right};
      if (slot == RightSlot) begin
        shifter_right <= {~sum_right[17], sum_right[14:0]};
        clamp_right   <= sum_right[17:15];
        sum_right     <= add_right ? sample_ext : '0;
      end else begin
        shifter_right <= shifter_right >> 1;
        if (add_right) begin
          sum_right <= sum_right + sample_ext;
        end
      end
      if (slot == LeftSlot) begin
        shifter_left <= {~sum_left[17], sum_left[14:0]};
        clamp_left   <= sum_left[17:15];
        sum_left     <= add_left ? sample_ext : '0;
      end else begin
        shifter_left <= shifter_left >> 1;
        if (add_left) begin
          sum_left <= sum_left + sample_ext;
        end
      end
    end
  end

endmodule

// ===== design/smfs_ser.sv =====
module smfs_ser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [smfs_pkg::SlotWidth-1:0] slot,
  input  smfs_pkg::tap_t                 taps,
  output logic                           pending_bit
);
  import smfs_pkg::*;

  logic [WinWidth-1:0]  bit_window;
  logic [6:0]           top_capture;
  logic                 held_sign;
  logic [2:0]           held_exponent;
  logic [3:0]           phase;
  logic [SlotWidth-1:0] slot_back;
  logic                 merged;
  logic                 pending_next;

  assign phase     = slot[3:0];
  assign slot_back = slot - SlotWidth'(2);
  assign merged    = slot_back[SlotWidth-1] ? taps.right : taps.left;

  always_comb begin
    pending_next = 1'b0;
    priority if (phase == PhaseSign) begin
      pending_next = held_sign;
    end else if (phase <= PhaseExpLast) begin
      pending_next = held_exponent[2'(phase - 4'd1)];
    end else if (held_exponent != 3'd0) begin
      pending_next = bit_window[5'(held_exponent - 3'd1)];
    end else begin
      pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_window    <= '0;
      top_capture   <= '0;
      held_sign     <= 1'b0;
      held_exponent <= '0;
      pending_bit   <= 1'b0;
    end else if (step) begin
      if (phase == PhaseCapture) begin
        top_capture <= {merged, bit_window[20:15]};
      end
      if (phase == PhaseSearch) begin
        held_exponent <= lead_exponent(top_capture);
        held_sign     <= top_capture[6];
      end
      bit_window  <= {merged, bit_window[WinWidth-1:1]};
      pending_bit <= pending_next;
    end
  end

endmodule

// ===== design/stereo_mix_float_serializer.sv =====
// an accepted input word's output word is held in the output register from the next cycle
// throughput: one word per cycle unless stalled; single register stage after state update
// the output register frees the input side whenever it is empty or being taken
// reset (rst, synchronous): slot counter, sums, shifters, delays and window clear to zero
// and the output register is emptied
module stereo_mix_float_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [smfs_pkg::InWidth-1:0]  s_tdata,  // sample[13:0], add_left, add_right
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [smfs_pkg::OutWidth-1:0] m_tdata   // serial_bit, slot_index[4:0], zero pad
);
  import smfs_pkg::*;

  logic                 accept;
  logic [SlotWidth-1:0] slot_counter;
  tap_t                 taps;
  logic                 pending_bit;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  smfs_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .slot      (slot_counter),
    .sample    (s_tdata[SampleWidth-1:0]),
    .add_left  (s_tdata[SampleWidth]),
    .add_right (s_tdata[SampleWidth+1]),
    .taps      (taps)
  );

  smfs_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .slot        (slot_counter),
    .taps        (taps),
    .pending_bit (pending_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter <= '0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
    end else begin
      if (accept) begin
        slot_counter <= slot_counter + SlotWidth'(1);
        m_tvalid     <= 1'b1;
        m_tdata      <= {(OutWidth-SlotWidth-1)'(0), slot_counter, pending_bit};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted word did not reach the output register");

  a_slot_tag : assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tdata[SlotWidth:1] == $past(slot_counter))
    else $error("output slot does not match the slot of the accepted word");

  a_reset_empty : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("output register not empty after reset");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import smfs_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PrintLimit = 40;

  typedef struct packed {
    logic       serial_bit;
    logic [4:0] slot;
  } pin_word_t;

  typedef enum {FrameFullPos, FrameFullNeg, FrameScaled, FrameNoise} frame_kind_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InWidth-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutWidth-1:0] m_tdata;

  // mixer state mirrored for prediction
  logic [4:0]  slot_ctr;
  logic [19:0] acc_l, acc_r;
  logic [15:0] shift_l, shift_r;
  logic [2:0]  clamp_l, clamp_r;
  logic [3:0]  dly_l, dly_r;
  logic [20:0] window;
  logic [6:0]  capture;
  logic        sign_q;
  logic [2:0]  exp_q;
  logic        next_bit;
  logic        pin;

  pin_word_t pin_q[$];
  int        errors = 0;
  int        cycle_cnt = 0;
  int        rx_hold = 0;
  logic      calm = 1'b0;

  stereo_mix_float_serializer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),  // sample[13:0], add_left, add_right
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)   // serial_bit, slot_index[4:0], zero pad
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [2:0] find_exponent(input logic [6:0] cap);
    logic [5:0] mag;
    logic [2:0] e;
    logic       found;
    mag = cap[6] ? cap[5:0] : ~cap[5:0];
    e = 3'd1;
    found = 1'b0;
    for (int i = 5; i >= 0; i--) begin
      if (!found && mag[i]) begin
        e = 3'(i + 2);
        found = 1'b1;
      end
    end
    return e;
  endfunction

  // equal top bits means the sum is in range, otherwise saturate by direction
  function automatic logic clamped_bit(input logic [2:0] clamp, input logic lsb);
    if (clamp[2] == clamp[1] && clamp[1] == clamp[0]) begin
      return lsb;
    end
    return !clamp[2];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic clear_mixer();
    slot_ctr = '0; acc_l = '0; acc_r = '0; shift_l = '0; shift_r = '0;
    clamp_l = '0; clamp_r = '0; dly_l = '0; dly_r = '0; window = '0;
    capture = '0; sign_q = 1'b0; exp_q = '0; next_bit = 1'b0; pin = 1'b0;
  endtask

  task automatic advance_mixer(input logic [13:0] smp, input logic l, input logic r,
                               output pin_word_t w);
    logic [4:0]  slot;
    logic [3:0]  phase;
    logic [19:0] s;
    logic        nb;
    logic        mb;
    logic        nl, nr;
    slot = slot_ctr;
    phase = slot[3:0];
    s = {{6{smp[13]}}, smp};
    pin = next_bit;

    nb = 1'b0;
    if (phase == PhaseSign) begin
      nb = sign_q;
    end else if (phase <= PhaseExpLast) begin
      nb = exp_q[phase[1:0] - 2'd1];
    end else if (exp_q != 3'd0) begin
      nb = window[exp_q - 3'd1];
    end

    mb = (5'(slot + 5'd30) < 5'd16) ? dly_l[3] : dly_r[3];
    if (phase == PhaseCapture) begin
      capture = {mb, window[20:15]};
    end
    if (phase == PhaseSearch) begin
      exp_q = find_exponent(capture);
      sign_q = capture[6];
    end
    window = {mb, window[20:1]};
    next_bit = nb;

    nl = clamped_bit(clamp_l, shift_l[0]);
    nr = clamped_bit(clamp_r, shift_r[0]);
    dly_l = {dly_l[2:0], nl};
    dly_r = {dly_r[2:0], nr};

    if (slot == RightSlot) begin
      shift_r = {~acc_r[17], acc_r[14:0]};
      clamp_r = acc_r[17:15];
    end else begin
      shift_r = shift_r >> 1;
    end
    if (slot == LeftSlot) begin
      shift_l = {~acc_l[17], acc_l[14:0]};
      clamp_l = acc_l[17:15];
    end else begin
      shift_l = shift_l >> 1;
    end

    if (slot == RightSlot) begin
      acc_r = r ? s : 20'd0;
    end else if (r) begin
      acc_r = acc_r + s;
    end
    if (slot == LeftSlot) begin
      acc_l = l ? s : 20'd0;
    end else if (l) begin
      acc_l = acc_l + s;
    end

    w.serial_bit = pin;
    w.slot = slot;
    slot_ctr = slot + 5'd1;
  endtask

  task automatic report(input string what);
    errors++;
    if (errors <= PrintLimit) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    end
  endtask

  always @(posedge clk) begin : monitor
    pin_word_t want;
    pin_word_t made;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pin_q.size() == 0) begin
          report("output word with nothing expected");
        end else begin
          want = pin_q.pop_front();
          if (m_tdata[0] !== want.serial_bit) begin
            report($sformatf("serial_bit %b, expected %b (slot %0d)",
                             m_tdata[0], want.serial_bit, want.slot));
          end
          if (m_tdata[5:1] !== want.slot) begin
            report($sformatf("slot_index %0d, expected %0d", m_tdata[5:1], want.slot));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        advance_mixer(s_tdata[13:0], s_tdata[14], s_tdata[15], made);
        pin_q.push_back(made);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 99) < 25) begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          stall--;
        end else begin
          m_tready <= 1'b1;
        end
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [13:0] smp, input logic l, input logic r);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {r, l, smp};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_empty();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    int   amp_log;
    int   bias;
    int   pl, pr;
    int   val;
    logic l, r;
    amp_log = $urandom_range(0, 13);
    bias = $urandom_range(0, 2);
    pl = $urandom_range(0, 100);
    pr = $urandom_range(0, 100);
    for (int i = 0; i < 32; i++) begin
      case (kind)
        FrameFullPos: begin
          val = $urandom_range(4096, 8191);
          l = 1'b1;
          r = 1'b1;
        end
        FrameFullNeg: begin
          val = -int'($urandom_range(4096, 8192));
          l = 1'b1;
          r = 1'b1;
        end
        FrameScaled: begin
          val = $urandom_range(0, (1 << amp_log) - 1);
          if (bias == 1 || (bias == 2 && $urandom_range(0, 1) == 1)) begin
            val = -val - 1;
          end
          l = $urandom_range(0, 99) < pl;
          r = $urandom_range(0, 99) < pr;
        end
        default: begin
          val = $urandom_range(0, 16383);
          l = 1'($urandom_range(0, 1));
          r = 1'($urandom_range(0, 1));
        end
      endcase
      send_word(val[13:0], l, r);
    end
  endtask

  // right sum restarts on the fourteenth word after reset, left on the thirtieth
  task automatic test_directed_extremes();
    logic [13:0] pick[8];
    pick = '{14'h1FFF, 14'h2000, 14'h0000, 14'h3FFF, 14'h0001, 14'h2AAA, 14'h1555, 14'h0100};
    calm = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_word(pick[i % 8], i[0], i[1]);
    end
    calm = 1'b0;
  endtask

  // long receiver hold while full-scale frames push both sums into saturation
  task automatic test_saturation_backpressure();
    calm = 1'b1;
    rx_hold = 90;
    send_frame(FrameFullPos);
    send_frame(FrameFullPos);
    calm = 1'b0;
    send_frame(FrameFullNeg);
    send_frame(FrameFullNeg);
  endtask

  task automatic test_drain_pause();
    send_frame(FrameScaled);
    wait_empty();
    send_frame(FrameNoise);
  endtask

  task automatic test_random_frames();
    int k;
    for (int f = 0; f < 30; f++) begin
      calm = ($urandom_range(0, 5) == 0);
      k = $urandom_range(0, 9);
      if (k == 0) begin
        send_frame(FrameFullPos);
      end else if (k == 1) begin
        send_frame(FrameFullNeg);
      end else if (k == 2) begin
        send_frame(FrameNoise);
      end else begin
        send_frame(FrameScaled);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    clear_mixer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_saturation_backpressure();
    test_drain_pause();
    test_random_frames();

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_empty();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== stereo_mix_float_serializer.f =====
design/smfs_pkg.sv
design/smfs_mix.sv
design/smfs_ser.sv
design/stereo_mix_float_serializer.sv
bench/tb.sv
